// File: rtl/core/phbar_pkg.sv
`timescale 1ns / 1ps

package phbar_pkg;

  localparam int MAX_PARTICIPANTS_DEF = 16;
  localparam int PHASE_BITS_DEF       = 16;

  // field widths
  localparam int OPCODE_W  = 2;
  localparam int PART_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int CUR_W     = 16;
  localparam int MASK_W    = 16;
  localparam int CFG_W     = 5;

  // stream word widths, padded to whole bytes
  localparam int IN_W  = 8;
  localparam int OUT_W = 40;

  localparam logic [CFG_W-1:0] COUNT_RESET = 5'd16;

  localparam logic [OPCODE_W-1:0] OP_ADVANCE  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADV_WAIT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WAITING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd3;

endpackage

// File: rtl/core/phbar_cnt_mem.sv
`timescale 1ns / 1ps

module phbar_cnt_mem #(
  parameter int DEPTH      = phbar_pkg::MAX_PARTICIPANTS_DEF,
  parameter int PHASE_BITS = phbar_pkg::PHASE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [PHASE_BITS-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [PHASE_BITS-1:0]    rdata
);

  logic [PHASE_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      written;
  logic [PHASE_BITS-1:0] rd_q;
  logic                  rd_written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_written <= written[raddr];
    end
  end

  assign rdata = rd_written ? rd_q : '0;

endmodule

// File: rtl/core/phbar_alu.sv
`timescale 1ns / 1ps

module phbar_alu #(
  parameter int PHASE_BITS = phbar_pkg::PHASE_BITS_DEF
) (
  input  logic [PHASE_BITS-1:0] a,
  input  logic [PHASE_BITS-1:0] b,
  input  logic [PHASE_BITS-1:0] x,
  output logic                  lt,
  output logic [PHASE_BITS-1:0] inc
);

  assign lt  = a < b;
  // hold at all ones
  assign inc = (x == '1) ? x : x + PHASE_BITS'(1);

endmodule

// File: rtl/core/phaser_barrier_unit_core.sv
`timescale 1ns / 1ps
// Advance: INC, MIN_WALK over the n active counters, where n is the active count,
// REL_WALK over all counters (skipped while nobody waits), FIN and OUT.
// Query, bad participant or caller already waiting: MIN_WALK over the n counters, then OUT.
// One word at a time; s_axis_tready is high only between words. The walks use the single
// counter read port and comparator, one counter per cycle.
// Reset (rst, synchronous): counters read as zero, nobody waiting, count 16.
module phaser_barrier_unit_core #(
  parameter int MAX_PARTICIPANTS = phbar_pkg::MAX_PARTICIPANTS_DEF,
  parameter int PHASE_BITS       = phbar_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [phbar_pkg::IN_W-1:0]  s_axis_tdata,   // opcode, participant
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [phbar_pkg::OUT_W-1:0] m_axis_tdata,   // status, current_phase, release_mask
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [phbar_pkg::CFG_W-1:0] cfg_data        // participant_count
);

  localparam int IDX_W = $clog2(MAX_PARTICIPANTS);
  localparam int CNT_W = $clog2(MAX_PARTICIPANTS + 1);

  typedef enum logic [2:0] {
    IDLE,
    INC,
    MIN_WALK,
    REL_WALK,
    FIN,
    OUT
  } state_t;

  state_t                          state;
  logic [phbar_pkg::CFG_W-1:0]     pcount;
  logic [MAX_PARTICIPANTS-1:0]     waiting;
  logic [MAX_PARTICIPANTS-1:0]     rel;
  logic [phbar_pkg::OPCODE_W-1:0]  op_q;
  logic [IDX_W-1:0]                who;
  logic [phbar_pkg::STATUS_W-1:0]  status;
  logic                            adv_ok;
  logic [PHASE_BITS-1:0]           min_q;
  logic [PHASE_BITS-1:0]           newval;
  logic [CNT_W-1:0]                ctr;
  logic [IDX_W-1:0]                pidx;
  logic                            pv;

  logic [CNT_W-1:0]                act_n;
  logic [phbar_pkg::OPCODE_W-1:0]  op_in;
  logic [phbar_pkg::PART_W-1:0]    part_in;
  logic [IDX_W-1:0]                who_in;
  logic                            in_adv;
  logic                            in_bad;
  logic [IDX_W-1:0]                raddr;
  logic [PHASE_BITS-1:0]           rdata;
  logic [PHASE_BITS-1:0]           cmp_a;
  logic [PHASE_BITS-1:0]           cmp_b;
  logic                            cmp_lt;
  logic [PHASE_BITS-1:0]           inc_val;
  logic [31:0]                     cur_wide;
  logic [63:0]                     rel_wide;

  assign op_in   = s_axis_tdata[phbar_pkg::OPCODE_W-1:0];
  assign part_in = s_axis_tdata[phbar_pkg::OPCODE_W +: phbar_pkg::PART_W];
  assign who_in  = IDX_W'(part_in);
  assign in_adv  = (op_in == phbar_pkg::OP_ADVANCE) || (op_in == phbar_pkg::OP_ADV_WAIT);
  assign in_bad  = 32'(part_in) >= 32'(act_n);

  assign s_axis_tready = (state == IDLE);
  assign cfg_ready     = 1'b1;

  always_comb begin
    if (pcount == '0) begin
      act_n = CNT_W'(1);
    end else if (32'(pcount) > 32'(MAX_PARTICIPANTS)) begin
      act_n = CNT_W'(MAX_PARTICIPANTS);
    end else begin
      act_n = CNT_W'(pcount);
    end
  end

  always_comb begin
    if (state == IDLE) begin
      raddr = who_in;
    end else begin
      raddr = ctr[IDX_W-1:0];
    end
  end

  // one comparator, operands picked by the sequencer
  always_comb begin
    if (state == MIN_WALK) begin
      cmp_a = rdata;
      cmp_b = min_q;
    end else if (state == FIN) begin
      cmp_a = min_q;
      cmp_b = newval;
    end else begin
      cmp_a = min_q;
      cmp_b = rdata;
    end
  end

  phbar_cnt_mem #(
    .DEPTH      (MAX_PARTICIPANTS),
    .PHASE_BITS (PHASE_BITS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (state == INC),
    .waddr (who),
    .wdata (inc_val),
    .raddr (raddr),
    .rdata (rdata)
  );

  phbar_alu #(
    .PHASE_BITS (PHASE_BITS)
  ) u_alu (
    .a   (cmp_a),
    .b   (cmp_b),
    .x   (rdata),
    .lt  (cmp_lt),
    .inc (inc_val)
  );

  assign cur_wide = 32'(min_q);
  assign rel_wide = 64'(rel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      pcount        <= phbar_pkg::COUNT_RESET;
      waiting       <= '0;
      m_axis_tvalid <= 1'b0;
      pv            <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pcount <= cfg_data;
      end
      // OUT reloads the word itself when the old one leaves
      if (m_axis_tvalid && m_axis_tready && state != OUT) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            op_q   <= op_in;
            who    <= who_in;
            rel    <= '0;
            ctr    <= '0;
            pv     <= 1'b0;
            min_q  <= '1;
            adv_ok <= 1'b0;
            if (!in_adv) begin
              status <= phbar_pkg::ST_DONE;
              state  <= MIN_WALK;
            end else if (in_bad) begin
              status <= phbar_pkg::ST_BAD;
              state  <= MIN_WALK;
            end else if (waiting[who_in]) begin
              status <= phbar_pkg::ST_ALREADY;
              state  <= MIN_WALK;
            end else begin
              status <= phbar_pkg::ST_DONE;
              adv_ok <= 1'b1;
              state  <= INC;
            end
          end
        end

        INC: begin
          newval <= inc_val;
          state  <= MIN_WALK;
        end

        MIN_WALK: begin
          if (pv && cmp_lt) begin
            min_q <= rdata;
          end
          if (ctr != act_n) begin
            pidx <= ctr[IDX_W-1:0];
            ctr  <= ctr + CNT_W'(1);
            pv   <= 1'b1;
          end else begin
            ctr <= '0;
            pv  <= 1'b0;
            if (!adv_ok) begin
              state <= OUT;
            end else if (waiting == '0) begin
              state <= FIN;
            end else begin
              state <= REL_WALK;
            end
          end
        end

        REL_WALK: begin
          // release a waiter unless the minimum is still below its counter
          if (pv && waiting[pidx] && !cmp_lt) begin
            rel[pidx] <= 1'b1;
          end
          if (ctr != CNT_W'(MAX_PARTICIPANTS)) begin
            pidx <= ctr[IDX_W-1:0];
            ctr  <= ctr + CNT_W'(1);
            pv   <= 1'b1;
          end else begin
            pv    <= 1'b0;
            state <= FIN;
          end
        end

        FIN: begin
          if (op_q == phbar_pkg::OP_ADV_WAIT && cmp_lt) begin
            waiting      <= (waiting & ~rel) | (MAX_PARTICIPANTS'(1) << who);
            status       <= phbar_pkg::ST_WAITING;
          end else begin
            waiting <= waiting & ~rel;
          end
          state <= OUT;
        end

        OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {6'b0, rel_wide[phbar_pkg::MASK_W-1:0],
                              cur_wide[phbar_pkg::CUR_W-1:0], status};
            m_axis_tvalid <= 1'b1;
            state         <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
